### rtl/rthi_pkg.sv
`default_nettype none
package rthi_pkg;

    // Pixel and result field widths
    localparam int unsigned PIX_W = 24;
    localparam int unsigned CH_W  = 8;
    localparam int unsigned HUE_W = 9;

    // Divider datapath widths and cell count (one quotient bit per cell)
    localparam int unsigned REM_W  = 16;
    localparam int unsigned Q_W    = 8;
    localparam int unsigned NCELLS = Q_W;

    // Hue sector offsets
    localparam logic [HUE_W-1:0] HUE_GREEN = 9'd120;
    localparam logic [HUE_W-1:0] HUE_BLUE  = 9'd240;
    localparam logic [HUE_W-1:0] HUE_WRAP  = 9'd360;

    // Which channel holds the maximum
    typedef enum logic [1:0] {
        SEC_RED   = 2'd0,
        SEC_GREEN = 2'd1,
        SEC_BLUE  = 2'd2
    } t_sector;

    // Byte order of the packed pixel
    typedef enum logic {
        ORDER_RED_LOW  = 1'b0,
        ORDER_RED_HIGH = 1'b1
    } t_order;

    // Data carried along the divider chain
    typedef struct packed {
        logic [REM_W-1:0] sat_rem;   // partial remainder, 255*delta / vmax
        logic [REM_W-1:0] sat_dsh;   // shifted divisor
        logic [Q_W-1:0]   sat_q;
        logic [REM_W-1:0] hue_rem;   // partial remainder, 60*|diff| / delta
        logic [REM_W-1:0] hue_dsh;
        logic [Q_W-1:0]   hue_q;
        logic [CH_W-1:0]  vmax;
        t_sector          sector;
        logic             hue_neg;   // difference was negative
        logic             grey;      // delta is zero
    } t_stage;

endpackage
`default_nettype wire

### rtl/rthi_if.sv
`default_nettype none
// Pixel input stream
interface rthi_pix_if;
    logic                         valid;
    logic                         ready;
    logic [rthi_pkg::PIX_W-1:0]   pixel;
    modport source (output valid, output pixel, input ready);
    modport sink   (input valid, input pixel, output ready);
endinterface

// HSV result stream
interface rthi_hsv_if;
    logic                         valid;
    logic                         ready;
    logic [rthi_pkg::HUE_W-1:0]   hue;
    logic [rthi_pkg::CH_W-1:0]    saturation;
    logic [rthi_pkg::CH_W-1:0]    brightness;
    modport source (output valid, output hue, output saturation, output brightness,
                    input ready);
    modport sink   (input valid, input hue, input saturation, input brightness,
                    output ready);
endinterface

// Configuration write channel (channel_order)
interface rthi_cfg_if;
    logic valid;
    logic ready;
    logic data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

### rtl/rthi_front.sv
`default_nettype none
module rthi_front (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_order,
    input  wire logic                        i_valid,
    input  wire logic [rthi_pkg::PIX_W-1:0]  i_pixel,
    output logic                             o_ready,
    output logic                             o_valid,
    output rthi_pkg::t_stage                 o_stage,
    input  wire logic                        i_dn_ready
);

    localparam int unsigned CH_W = rthi_pkg::CH_W;

    logic                   r_valid;
    rthi_pkg::t_stage       r_stage;
    rthi_pkg::t_stage       n_stage;
    logic                   w_en;

    logic [CH_W-1:0]        w_r, w_g, w_b;
    logic [CH_W-1:0]        w_max, w_min, w_delta;
    logic [CH_W:0]          w_diff;      // signed, 9 bits
    logic [CH_W-1:0]        w_mag;
    rthi_pkg::t_sector      w_sector;

    assign w_en    = !r_valid || i_dn_ready;
    assign o_ready = w_en;
    assign o_valid = r_valid;
    assign o_stage = r_stage;

    // Unpack channels, find max, min and hue sector
    always_comb begin
        w_g = i_pixel[15:8];
        if (rthi_pkg::t_order'(i_order) == rthi_pkg::ORDER_RED_HIGH) begin
            w_r = i_pixel[23:16];
            w_b = i_pixel[7:0];
        end else begin
            w_r = i_pixel[7:0];
            w_b = i_pixel[23:16];
        end
        w_max = w_r;
        w_min = w_r;
        if (w_g > w_max) w_max = w_g;
        if (w_b > w_max) w_max = w_b;
        if (w_g < w_min) w_min = w_g;
        if (w_b < w_min) w_min = w_b;
        w_delta = w_max - w_min;
        // red wins ties, then green
        if (w_r == w_max) begin
            w_sector = rthi_pkg::SEC_RED;
            w_diff   = {1'b0, w_g} - {1'b0, w_b};
        end else if (w_g == w_max) begin
            w_sector = rthi_pkg::SEC_GREEN;
            w_diff   = {1'b0, w_b} - {1'b0, w_r};
        end else begin
            w_sector = rthi_pkg::SEC_BLUE;
            w_diff   = {1'b0, w_r} - {1'b0, w_g};
        end
        w_mag = w_diff[CH_W] ? CH_W'(-w_diff) : w_diff[CH_W-1:0];
    end

    // Seed the divider chain: numerators and divisors aligned to the top quotient bit
    always_comb begin
        n_stage         = '0;
        n_stage.sat_rem = ({8'd0, w_delta} << 8) - {8'd0, w_delta};
        n_stage.sat_dsh = {8'd0, w_max} << (rthi_pkg::Q_W - 1);
        n_stage.hue_rem = ({8'd0, w_mag} << 6) - ({8'd0, w_mag} << 2);
        n_stage.hue_dsh = {8'd0, w_delta} << (rthi_pkg::Q_W - 1);
        n_stage.vmax    = w_max;
        n_stage.sector  = w_sector;
        n_stage.hue_neg = w_diff[CH_W];
        n_stage.grey    = (w_delta == '0);
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_en) begin
            r_valid <= i_valid;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_stage <= n_stage;
        end
    end

endmodule
`default_nettype wire

### rtl/rthi_cell.sv
`default_nettype none
module rthi_cell (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire rthi_pkg::t_stage  i_stage,
    output logic                   o_ready,
    output logic                   o_valid,
    output rthi_pkg::t_stage       o_stage,
    input  wire logic              i_dn_ready
);

    logic              r_valid;
    rthi_pkg::t_stage  r_stage;
    rthi_pkg::t_stage  n_stage;
    logic              w_en;

    assign w_en    = !r_valid || i_dn_ready;
    assign o_ready = w_en;
    assign o_valid = r_valid;
    assign o_stage = r_stage;

    // One restoring step for each division, then halve the divisors
    always_comb begin
        n_stage = i_stage;
        if (i_stage.sat_rem >= i_stage.sat_dsh) begin
            n_stage.sat_rem = i_stage.sat_rem - i_stage.sat_dsh;
            n_stage.sat_q   = {i_stage.sat_q[rthi_pkg::Q_W-2:0], 1'b1};
        end else begin
            n_stage.sat_q   = {i_stage.sat_q[rthi_pkg::Q_W-2:0], 1'b0};
        end
        if (i_stage.hue_rem >= i_stage.hue_dsh) begin
            n_stage.hue_rem = i_stage.hue_rem - i_stage.hue_dsh;
            n_stage.hue_q   = {i_stage.hue_q[rthi_pkg::Q_W-2:0], 1'b1};
        end else begin
            n_stage.hue_q   = {i_stage.hue_q[rthi_pkg::Q_W-2:0], 1'b0};
        end
        n_stage.sat_dsh = i_stage.sat_dsh >> 1;
        n_stage.hue_dsh = i_stage.hue_dsh >> 1;
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_en) begin
            r_valid <= i_valid;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_stage <= n_stage;
        end
    end

endmodule
`default_nettype wire

### rtl/rthi_back.sv
`default_nettype none
module rthi_back (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    input  wire rthi_pkg::t_stage            i_stage,
    output logic                             o_ready,
    output logic                             o_valid,
    output logic [rthi_pkg::HUE_W-1:0]       o_hue,
    output logic [rthi_pkg::CH_W-1:0]        o_sat,
    output logic [rthi_pkg::CH_W-1:0]        o_val,
    input  wire logic                        i_dn_ready
);

    localparam int unsigned HUE_W = rthi_pkg::HUE_W;

    logic                 r_valid;
    logic [HUE_W-1:0]     r_hue;
    logic [rthi_pkg::CH_W-1:0] r_sat;
    logic [rthi_pkg::CH_W-1:0] r_val;
    logic [HUE_W-1:0]     n_hue;
    logic [rthi_pkg::CH_W-1:0] n_sat;
    logic [HUE_W-1:0]     w_q;
    logic                 w_en;

    assign w_en    = !r_valid || i_dn_ready;
    assign o_ready = w_en;
    assign o_valid = r_valid;
    assign o_hue   = r_hue;
    assign o_sat   = r_sat;
    assign o_val   = r_val;

    // Apply sign and sector offset, wrap negative red hues, zero hue and saturation for grey
    always_comb begin
        w_q   = {1'b0, i_stage.hue_q};
        n_sat = i_stage.grey ? '0 : i_stage.sat_q;
        case (i_stage.sector)
            rthi_pkg::SEC_RED: begin
                if (i_stage.hue_neg && (w_q != '0)) n_hue = rthi_pkg::HUE_WRAP - w_q;
                else                                 n_hue = w_q;
            end
            rthi_pkg::SEC_GREEN: begin
                n_hue = i_stage.hue_neg ? rthi_pkg::HUE_GREEN - w_q
                                        : rthi_pkg::HUE_GREEN + w_q;
            end
            rthi_pkg::SEC_BLUE: begin
                n_hue = i_stage.hue_neg ? rthi_pkg::HUE_BLUE - w_q
                                        : rthi_pkg::HUE_BLUE + w_q;
            end
            default: begin
                n_hue = '0;
            end
        endcase
        if (i_stage.grey) n_hue = '0;
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_en) begin
            r_valid <= i_valid;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_hue <= n_hue;
            r_sat <= n_sat;
            r_val <= i_stage.vmax;
        end
    end

endmodule
`default_nettype wire

### rtl/rgb_to_hsv_integer_unit.sv
`default_nettype none
// Integer RGB to HSV converter. Accepts one packed 24-bit pixel per clock and
// returns hue (0..359 degrees, 0 for grey), saturation (255*delta/max,
// truncated) and brightness (the largest channel). Throughput is one pixel
// per cycle while the output is not stalled. Stages: an input stage that
// unpacks the pixel and finds max/min, a row of 8 divider cells that each
// resolve one quotient bit of both the saturation and the hue division, and
// an output register that applies the hue sector offset. Every stage holds
// its transaction when the one after it is full, so bubbles collapse and the
// input keeps accepting while a result waits at the output until all stages
// fill. The channel_order register (reset 0: red in the low byte; 1: red in
// the high byte) is written through the configuration channel, which is
// always ready, and should only change while the pipeline is empty.
module rgb_to_hsv_integer_unit (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    rthi_pix_if.sink     i_pixel,
    rthi_hsv_if.source   o_hsv,
    rthi_cfg_if.sink     i_cfg
);

    localparam int unsigned NCELLS = rthi_pkg::NCELLS;

    logic                r_channel_order;
    rthi_pkg::t_stage    w_stage [NCELLS+1];
    logic                w_valid [NCELLS+1];
    logic                w_ready [NCELLS+1];

    // Configuration register
    assign i_cfg.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_channel_order <= 1'b0;
        end else if (i_cfg.valid) begin
            r_channel_order <= i_cfg.data;
        end
    end

    // Input stage
    rthi_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_order    (r_channel_order),
        .i_valid    (i_pixel.valid),
        .i_pixel    (i_pixel.pixel),
        .o_ready    (i_pixel.ready),
        .o_valid    (w_valid[0]),
        .o_stage    (w_stage[0]),
        .i_dn_ready (w_ready[0])
    );

    // Divider cell row
    for (genvar k = 0; k < NCELLS; k++) begin : g_cell
        rthi_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_valid    (w_valid[k]),
            .i_stage    (w_stage[k]),
            .o_ready    (w_ready[k]),
            .o_valid    (w_valid[k+1]),
            .o_stage    (w_stage[k+1]),
            .i_dn_ready (w_ready[k+1])
        );
    end

    // Output stage
    rthi_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (w_valid[NCELLS]),
        .i_stage    (w_stage[NCELLS]),
        .o_ready    (w_ready[NCELLS]),
        .o_valid    (o_hsv.valid),
        .o_hue      (o_hsv.hue),
        .o_sat      (o_hsv.saturation),
        .o_val      (o_hsv.brightness),
        .i_dn_ready (o_hsv.ready)
    );

endmodule
`default_nettype wire

### tb/rgb_to_hsv_integer_unit_tb.sv
`default_nettype none
module rgb_to_hsv_integer_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUIET_LIMIT = 4000;   // cycles with no transaction at all
    localparam int DRAIN_PAD   = 12;     // pipeline latency plus margin
    localparam int PHASE_ITEMS = 175;
    localparam int HOLD_AFTER  = 100;    // result count that triggers the long hold
    localparam int HOLD_LEN    = 300;

    typedef struct packed {
        logic [rthi_pkg::HUE_W-1:0] hue;
        logic [rthi_pkg::CH_W-1:0]  sat;
        logic [rthi_pkg::CH_W-1:0]  val;
    } t_hsv;

    // Expected-result store plus HSV predictor
    class hsv_scoreboard;
        rthi_pkg::t_order order;
        t_hsv   expected_q[$];
        int     mismatches;

        function new();
            order      = rthi_pkg::ORDER_RED_LOW;
            mismatches = 0;
        endfunction

        function t_hsv convert(logic [rthi_pkg::PIX_W-1:0] px);
            int   lo, g, hi, r, b, vmax, vmin, delta, sat, hue;
            t_hsv res;
            lo = int'(px[7:0]);
            g  = int'(px[15:8]);
            hi = int'(px[23:16]);
            r  = (order == rthi_pkg::ORDER_RED_HIGH) ? hi : lo;
            b  = (order == rthi_pkg::ORDER_RED_HIGH) ? lo : hi;
            vmax = r;
            vmin = r;
            if (g > vmax) vmax = g;
            if (b > vmax) vmax = b;
            if (g < vmin) vmin = g;
            if (b < vmin) vmin = b;
            delta = vmax - vmin;
            sat = (vmax != 0) ? (255 * delta) / vmax : 0;
            hue = 0;
            // sector picked red first, then green, so ties go to the earlier channel
            if (sat != 0 && delta != 0) begin
                if (r == vmax)
                    hue = (60 * (g - b)) / delta;
                else if (g == vmax)
                    hue = 120 + (60 * (b - r)) / delta;
                else
                    hue = 240 + (60 * (r - g)) / delta;
            end
            if (hue < 0) hue += 360;
            res.hue = hue[rthi_pkg::HUE_W-1:0];
            res.sat = sat[rthi_pkg::CH_W-1:0];
            res.val = vmax[rthi_pkg::CH_W-1:0];
            return res;
        endfunction

        function void note_pixel(logic [rthi_pkg::PIX_W-1:0] px);
            expected_q.push_back(convert(px));
        endfunction

        function void check_result(t_hsv got);
            t_hsv want;
            if (expected_q.size() == 0) begin
                if (mismatches < 10)
                    $display("unexpected result: hue %0d sat %0d val %0d",
                             got.hue, got.sat, got.val);
                mismatches++;
                return;
            end
            want = expected_q.pop_front();
            if (got.hue !== want.hue || got.sat !== want.sat || got.val !== want.val) begin
                if (mismatches < 10)
                    $display("result error: expected hue %0d sat %0d val %0d, got %0d %0d %0d",
                             want.hue, want.sat, want.val, got.hue, got.sat, got.val);
                mismatches++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    rthi_pix_if pix_bus ();
    rthi_hsv_if hsv_bus ();
    rthi_cfg_if cfg_bus ();

    rgb_to_hsv_integer_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pixel (pix_bus),
        .o_hsv   (hsv_bus),
        .i_cfg   (cfg_bus)
    );

    hsv_scoreboard sb = new();

    int idle_pct  = 0;
    int stall_pct = 0;
    int results_seen = 0;
    int quiet_cycles = 0;
    bit long_hold_done = 0;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Transaction monitor
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (cfg_bus.valid && cfg_bus.ready)
                sb.order = rthi_pkg::t_order'(cfg_bus.data);
            if (pix_bus.valid && pix_bus.ready)
                sb.note_pixel(pix_bus.pixel);
            if (hsv_bus.valid && hsv_bus.ready) begin
                sb.check_result('{hue: hsv_bus.hue, sat: hsv_bus.saturation,
                                  val: hsv_bus.brightness});
                results_seen++;
            end
        end
    end

    // Watchdog on transaction activity
    always @(posedge i_clk) begin
        if ((pix_bus.valid && pix_bus.ready) || (hsv_bus.valid && hsv_bus.ready) ||
            (cfg_bus.valid && cfg_bus.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Result receiver: random stalls, plus one long hold so the pipe backs up
    initial begin
        hsv_bus.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (!long_hold_done && results_seen >= HOLD_AFTER) begin
                hsv_bus.ready <= 1'b0;
                repeat (HOLD_LEN) @(posedge i_clk);
                long_hold_done = 1;
            end
            hsv_bus.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Called at a clock edge; returns at the edge that accepts the pixel
    task automatic send_pixel(input logic [rthi_pkg::PIX_W-1:0] px);
        while ($urandom_range(99) < idle_pct) begin
            pix_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        pix_bus.valid <= 1'b1;
        pix_bus.pixel <= px;
        do @(posedge i_clk); while (!pix_bus.ready);
    endtask

    task automatic write_order(input rthi_pkg::t_order ord);
        cfg_bus.valid <= 1'b1;
        cfg_bus.data  <= ord;
        do @(posedge i_clk); while (!cfg_bus.ready);
        cfg_bus.valid <= 1'b0;
    endtask

    // Wait for every expected result, then let the pipe settle
    task automatic drain();
        pix_bus.valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_PAD) @(posedge i_clk);
    endtask

    // Stimulus
    initial begin
        logic [rthi_pkg::PIX_W-1:0] directed_px[12];
        logic [rthi_pkg::PIX_W-1:0] px;
        logic [rthi_pkg::CH_W-1:0]  c0, c1, c2;
        int idle_tab[4];
        int stall_tab[4];

        // black, white, grey, single channels, tied maxima, negative hue, tiny delta
        directed_px = '{24'h000000, 24'hffffff, 24'h808080, 24'h0000ff, 24'h00ff00,
                        24'hff0000, 24'h00ffff, 24'hff00ff, 24'hffff00, 24'h320ac8,
                        24'h010203, 24'h7f80fe};
        idle_tab  = '{0, 64, 0, 33};
        stall_tab = '{0, 0, 64, 33};

        pix_bus.valid <= 1'b0;
        pix_bus.pixel <= '0;
        cfg_bus.valid <= 1'b0;
        cfg_bus.data  <= 1'b0;
        i_rst_n       <= 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed pixels under both byte orders
        for (int o = 0; o < 2; o++) begin
            write_order(rthi_pkg::t_order'(o));
            foreach (directed_px[k])
                send_pixel(directed_px[k]);
            drain();
        end

        // Random phases: each idle and stall mode under both byte orders
        for (int p = 0; p < 8; p++) begin
            write_order(rthi_pkg::t_order'(p % 2));
            idle_pct  = idle_tab[p / 2];
            stall_pct = stall_tab[p / 2];
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                case ($urandom_range(9))
                    0: begin
                        // grey
                        c0 = 8'($urandom_range(255));
                        px = {c0, c0, c0};
                    end
                    1, 2: begin
                        // two channels tied at the maximum
                        c0 = 8'($urandom_range(255));
                        c2 = 8'($urandom_range(c0));
                        px = {c2, c0, c0};
                        case ($urandom_range(2))
                            1: px = {c0, c2, c0};
                            2: px = {c0, c0, c2};
                            default: ;
                        endcase
                    end
                    3: begin
                        // bytes at or next to the extremes
                        c0 = $urandom_range(1) ? 8'hff - 8'($urandom_range(1))
                                               : 8'($urandom_range(1));
                        c1 = $urandom_range(1) ? 8'hff - 8'($urandom_range(1))
                                               : 8'($urandom_range(1));
                        c2 = $urandom_range(1) ? 8'hff - 8'($urandom_range(1))
                                               : 8'($urandom_range(1));
                        px = {c2, c1, c0};
                    end
                    4: begin
                        // dark pixels, small deltas
                        c0 = 8'($urandom_range(3));
                        c1 = 8'($urandom_range(3));
                        c2 = 8'($urandom_range(3));
                        px = {c2, c1, c0};
                    end
                    default: px = 24'($urandom());
                endcase
                send_pixel(px);
            end
            drain();
        end

        if (sb.mismatches == 0 && sb.expected_q.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
`default_nettype wire

### files.f
rtl/rthi_pkg.sv
rtl/rthi_if.sv
rtl/rthi_front.sv
rtl/rthi_cell.sv
rtl/rthi_back.sv
rtl/rgb_to_hsv_integer_unit.sv
tb/rgb_to_hsv_integer_unit_tb.sv
